// File: rtl/core/pvma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvma_pkg
// Shared types, register codes and pixel merge functions for the planar
// video memory access core.
// ----------------------------------------------------------------------------
package pvma_pkg;

    localparam int ROW_BYTES_DEF = 128;
    localparam int ROW_COUNT_DEF = 256;

    localparam int OFFSET_W = 15;
    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 8;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] WMODE_MASK   = 2'd0;
    localparam logic [1:0] WMODE_LATCH  = 2'd1;
    localparam logic [1:0] WMODE_COLOR  = 2'd2;
    localparam logic [1:0] WMODE_UNUSED = 2'd3;

    localparam logic [3:0] COLOR_ALIAS_SRC = 4'hF;
    localparam logic [3:0] COLOR_ALIAS_DST = 4'h4;

    typedef enum logic [1:0] {
        CFG_WRITE_MODE,
        CFG_PIXEL_WRITE_MASK,
        CFG_READ_PLANE,
        CFG_PLANE_MAP_MASK
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_MERGE
    } seq_state_t;

    // color 15 shares its RGB value with color 4
    function automatic logic [3:0] store_color(input logic [3:0] c);
        logic [3:0] r;
        begin
            r = (c == COLOR_ALIAS_SRC) ? COLOR_ALIAS_DST : c;
            return r;
        end
    endfunction

    // new word for a write; pixel 0 (leftmost) sits in the top nibble
    function automatic logic [WORD_W-1:0] merge_word(
        input logic [WORD_W-1:0] old_word,
        input logic [1:0]        mode,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] pix_mask,
        input logic [3:0]        map_mask,
        input logic [WORD_W-1:0] latches
    );
        logic [WORD_W-1:0] w;
        logic [3:0]        c;
        logic [3:0]        lc;
        begin
            w = old_word;
            for (int i = 0; i < 8; i++) begin
                c  = old_word[WORD_W-1-4*i -: 4];
                lc = {latches[24+7-i], latches[16+7-i], latches[8+7-i], latches[7-i]};
                case (mode)
                    WMODE_MASK:
                    begin
                        w[WORD_W-1-4*i -: 4] =
                            store_color((c & ~map_mask) | (data[7-i] ? map_mask : 4'h0));
                    end
                    WMODE_LATCH:
                    begin
                        w[WORD_W-1-4*i -: 4] = store_color(lc);
                    end
                    WMODE_COLOR:
                    begin
                        if (pix_mask[7-i])
                        begin
                            w[WORD_W-1-4*i -: 4] = store_color(data[3:0]);
                        end
                    end
                    default:
                    begin
                        w[WORD_W-1-4*i -: 4] = c;
                    end
                endcase
            end
            return w;
        end
    endfunction

    // latch image of a word: byte p holds plane p, msb leftmost
    function automatic logic [WORD_W-1:0] plane_split(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] lat;
        begin
            lat = '0;
            for (int i = 0; i < 8; i++) begin
                for (int p = 0; p < 4; p++) begin
                    lat[8*p + 7 - i] = word[WORD_W-4-4*i + p];
                end
            end
            return lat;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/planar_video_memory_access_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// planar_video_memory_access_core
// Planar video memory with EGA-style read latches and write modes 0, 1, 2.
// ----------------------------------------------------------------------------
// When ROW_BYTES*ROW_COUNT is a power of two or at least 32768, each request
// passes a read state for the synchronous read of the single-port word
// memory and a merge state to merge and write back (or return read data).
// For other depths the offset is first reduced modulo the depth by a shared
// compare/subtract unit, one shifted copy of the depth per cycle. A new
// request is taken in the write-back cycle of the previous one. Results on
// a read wait in an output register;
// the block only holds off when a second read finds that register still full.
// The word memory has no reset: reading a word before it was written gives
// undefined pixels. Read latches reset to zero.
// ----------------------------------------------------------------------------
module planar_video_memory_access_core #(
    parameter int ROW_BYTES = pvma_pkg::ROW_BYTES_DEF,
    parameter int ROW_COUNT = pvma_pkg::ROW_COUNT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       cfg_write,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [pvma_pkg::CFG_W-1:0] cfg_data,

    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       command,
    input  wire logic [pvma_pkg::OFFSET_W-1:0] byte_offset,
    input  wire logic [pvma_pkg::BYTE_W-1:0]   write_data,

    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [pvma_pkg::BYTE_W-1:0]     read_data
);
    import pvma_pkg::*;

    localparam int DEPTH     = ROW_BYTES * ROW_COUNT;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit DEPTH_P2  = ((DEPTH & (DEPTH - 1)) == 0);
    localparam int OFF_SPAN  = 1 << OFFSET_W;
    localparam int RED_STEPS = (DEPTH_P2 || DEPTH >= OFF_SPAN) ? 0 :
                               $clog2((OFF_SPAN - 1) / DEPTH + 1);
    localparam int SW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    // configuration
    logic [1:0]        write_mode_reg;
    logic [BYTE_W-1:0] pixel_write_mask_reg;
    logic [1:0]        read_plane_reg;
    logic [3:0]        plane_map_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_mode_reg       <= WMODE_COLOR;
            pixel_write_mask_reg <= '0;
            read_plane_reg       <= 2'd0;
            plane_map_mask_reg   <= 4'hF;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WRITE_MODE:       write_mode_reg       <= cfg_data[1:0];
                CFG_PIXEL_WRITE_MASK: pixel_write_mask_reg <= cfg_data[BYTE_W-1:0];
                CFG_READ_PLANE:       read_plane_reg       <= cfg_data[1:0];
                CFG_PLANE_MAP_MASK:   plane_map_mask_reg   <= cfg_data[3:0];
            endcase
        end
    end

    // sequencer
    seq_state_t state_reg, state_next;

    logic                cmd_reg;
    logic [OFFSET_W-1:0] red_reg;
    logic [BYTE_W-1:0]   data_reg;
    logic [SW-1:0]       step_reg;
    logic [WORD_W-1:0]   rdata_reg;
    logic [WORD_W-1:0]   latch_reg;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   read_data_reg;

    logic                merge_stall;
    logic                accept;
    logic                merge_done;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [31:0]         shifted_depth;
    logic                sub_hit;
    logic [WORD_W-1:0]   merged_word;
    logic [BYTE_W-1:0]   plane_bits;

    assign merge_stall = (cmd_reg == CMD_READ) && out_valid_reg && !out_ready;
    assign accept      = in_valid && in_ready;
    assign merge_done  = (state_reg == ST_MERGE) && !merge_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (RED_STEPS > 0) ? ST_REDUCE : ST_READ;
                end
            end
            ST_REDUCE:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (!merge_stall)
                begin
                    if (in_valid)
                    begin
                        state_next = (RED_STEPS > 0) ? ST_REDUCE : ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        mem_we   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_REDUCE, ST_READ:
            begin
                in_ready = 1'b0;
            end
            ST_MERGE:
            begin
                in_ready = !merge_stall;
                mem_we   = !merge_stall && (cmd_reg == CMD_WRITE) &&
                           (write_mode_reg != WMODE_UNUSED);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // shared compare/subtract for offset modulo depth
    assign shifted_depth = 32'(DEPTH) << step_reg;
    assign sub_hit       = {{(32-OFFSET_W){1'b0}}, red_reg} >= shifted_depth;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            red_reg  <= byte_offset;
            data_reg <= write_data;
            step_reg <= SW'(RED_STEPS - 1);
        end
        else if (state_reg == ST_REDUCE)
        begin
            if (sub_hit)
            begin
                red_reg <= red_reg - shifted_depth[OFFSET_W-1:0];
            end
            step_reg <= step_reg - SW'(1);
        end
    end

    // a one-word store has a single address
    assign mem_addr = (DEPTH > 1) ? AW'(red_reg) : '0;

    // word memory
    logic [WORD_W-1:0] pixel_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pixel_mem[mem_addr] <= merged_word;
        end
        if (state_reg == ST_READ)
        begin
            rdata_reg <= pixel_mem[mem_addr];
        end
    end

    assign merged_word = merge_word(rdata_reg, write_mode_reg, data_reg,
                                    pixel_write_mask_reg, plane_map_mask_reg, latch_reg);

    always_comb
    begin
        plane_bits = '0;
        for (int i = 0; i < 8; i++) begin
            plane_bits[7-i] = rdata_reg[WORD_W-4-4*i + int'(read_plane_reg)];
        end
    end

    // read latches and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (merge_done && (cmd_reg == CMD_READ))
            begin
                latch_reg     <= plane_split(rdata_reg);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (merge_done && (cmd_reg == CMD_READ))
        begin
            read_data_reg <= plane_bits;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for planar_video_memory_access_core: a directed script
// of corner cases, then randomized reads and writes over eight register
// settings under four throttling patterns, all checked against an in-bench
// model of the pixel store, the plane latches and the write modes.
// ----------------------------------------------------------------------------
module tb;
    import pvma_pkg::*;

    localparam int STORE_WORDS   = ROW_BYTES_DEF * ROW_COUNT_DEF;
    localparam int POOL_SIZE     = 16;
    localparam int SEGMENT_ITEMS = 82;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    typedef struct {
        bit          is_cfg;
        cfg_index_t  reg_idx;
        logic [7:0]  reg_val;
        logic        cmd;
        logic [14:0] off;
        logic [7:0]  wdata;
        bit          has_known;
        logic [7:0]  known;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [14:0] byte_offset;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;

    // model state
    logic [31:0] video_words [int];
    logic [31:0] latch_planes;
    logic [1:0]  sh_write_mode;
    logic [7:0]  sh_pixel_mask;
    logic [1:0]  sh_read_plane;
    logic [3:0]  sh_map_mask;

    logic [7:0]  pending_reads [$];
    script_row_t directed_script [$];
    logic [14:0] addr_pool [POOL_SIZE];

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int requests_sent;
    int reads_checked;
    int writes_per_mode [4];
    int quiet_cycles;

    planar_video_memory_access_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .byte_offset(byte_offset),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [3:0] palette_alias(input logic [3:0] c);
        return (c == 4'hF) ? 4'h4 : c;
    endfunction

    // true when the request depends on the current contents of the word
    function automatic bit reads_old_word(input logic cmd);
        return (cmd == CMD_READ) || (sh_write_mode == WMODE_MASK) ||
               (sh_write_mode == WMODE_COLOR && sh_pixel_mask != 8'hFF);
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic predict_access(input logic cmd, input logic [14:0] off,
                                  input logic [7:0] wdata, input bit has_known,
                                  input logic [7:0] known);
        int          a;
        logic [31:0] w;
        logic [3:0]  c;
        logic [7:0]  rd;
        logic [31:0] lat;
        a   = int'(off) % STORE_WORDS;
        w   = video_words.exists(a) ? video_words[a] : 32'h0;
        rd  = '0;
        lat = '0;
        requests_sent++;
        if (cmd == CMD_READ)
        begin
            for (int i = 0; i < 8; i++)
            begin
                c = w[31-4*i -: 4];
                rd[7-i] = c[sh_read_plane];
                for (int p = 0; p < 4; p++)
                    lat[8*p + 7 - i] = c[p];
            end
            latch_planes = lat;
            pending_reads.push_back(has_known ? known : rd);
        end
        else
        begin
            writes_per_mode[sh_write_mode]++;
            if (sh_write_mode != WMODE_UNUSED)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    c = w[31-4*i -: 4];
                    case (sh_write_mode)
                        WMODE_MASK:
                            w[31-4*i -: 4] = palette_alias((c & ~sh_map_mask) |
                                                 (wdata[7-i] ? sh_map_mask : 4'h0));
                        WMODE_LATCH:
                            w[31-4*i -: 4] = palette_alias({latch_planes[24+7-i],
                                                 latch_planes[16+7-i],
                                                 latch_planes[8+7-i], latch_planes[7-i]});
                        default:
                            if (sh_pixel_mask[7-i])
                                w[31-4*i -: 4] = palette_alias(wdata[3:0]);
                    endcase
                end
                video_words[a] = w;
            end
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic cmd, input logic [14:0] off,
                                input logic [7:0] wdata, input bit has_known,
                                input logic [7:0] known);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        byte_offset <= off;
        write_data  <= wdata;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_access(cmd, off, wdata, has_known, known);
        @(negedge clk);
    endtask

    // wait for all reads to return, then let any trailing write finish
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_WRITE_MODE:       sh_write_mode = val[1:0];
            CFG_PIXEL_WRITE_MASK: sh_pixel_mask = val;
            CFG_READ_PLANE:       sh_read_plane = val[1:0];
            default:              sh_map_mask   = val[3:0];
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic pick_settings();
        int         m;
        logic [7:0] pm;
        logic [3:0] mm;
        m = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0:       pm = 8'h00;
            1:       pm = 8'hFF;
            default: pm = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
            0:       mm = 4'h0;
            1:       mm = 4'hF;
            default: mm = 4'($urandom_range(0, 15));
        endcase
        write_register(CFG_WRITE_MODE, (m == 9) ? {6'd0, WMODE_UNUSED} : 8'(m % 3));
        write_register(CFG_PIXEL_WRITE_MASK, pm);
        write_register(CFG_READ_PLANE, 8'($urandom_range(0, 3)));
        write_register(CFG_PLANE_MAP_MASK, {4'd0, mm});
    endtask

    task automatic random_access();
        logic        cmd;
        logic [14:0] off;
        logic [7:0]  wdata;
        cmd   = ($urandom_range(0, 99) < 45) ? CMD_READ : CMD_WRITE;
        wdata = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 15)
            off = 15'($urandom_range(0, 32767));
        else
            off = addr_pool[$urandom_range(0, POOL_SIZE-1)];
        // never touch a word whose contents are still undefined
        if (!video_words.exists(int'(off) % STORE_WORDS) && reads_old_word(cmd))
            off = addr_pool[$urandom_range(0, POOL_SIZE-1)];
        send_request(cmd, off, wdata, 1'b0, 8'h00);
    endtask

    function automatic void add_reg(input cfg_index_t idx, input logic [7:0] val);
        script_row_t r;
        r = '{reg_idx: CFG_WRITE_MODE, default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        directed_script.push_back(r);
    endfunction

    function automatic void add_req(input logic cmd, input logic [14:0] off,
                                    input logic [7:0] wdata, input bit has_known,
                                    input logic [7:0] known);
        script_row_t r;
        r = '{reg_idx: CFG_WRITE_MODE, default: '0};
        r.cmd       = cmd;
        r.off       = off;
        r.wdata     = wdata;
        r.has_known = has_known;
        r.known     = known;
        directed_script.push_back(r);
    endfunction

    // outputs sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reads.size() == 0)
                note_error($sformatf("unexpected read result %02h", read_data));
            else
            begin
                if (read_data !== pending_reads[0])
                    note_error($sformatf("read_data mismatch: expected %02h, got %02h",
                                         pending_reads[0], read_data));
                void'(pending_reads.pop_front());
                reads_checked++;
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("planar_video_memory_access_core verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_READ;
        byte_offset    = '0;
        write_data     = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        errors         = 0;
        requests_sent  = 0;
        reads_checked  = 0;
        writes_per_mode = '{default: 0};
        latch_planes   = '0;
        sh_write_mode  = WMODE_COLOR;
        sh_pixel_mask  = 8'h00;
        sh_read_plane  = 2'd0;
        sh_map_mask    = 4'hF;

        // reset values: color mode, no pixels enabled, plane 0, all planes mapped
        add_reg(CFG_PIXEL_WRITE_MASK, 8'hFF);
        add_req(CMD_WRITE, 15'h0000, 8'h0F, 0, 8'h00);   // color 15 lands as 4
        add_req(CMD_WRITE, 15'h7FFF, 8'hF3, 0, 8'h00);   // upper data bits dropped
        add_req(CMD_READ,  15'h0000, 8'h00, 1, 8'h00);
        add_req(CMD_READ,  15'h7FFF, 8'hFF, 1, 8'hFF);
        add_reg(CFG_READ_PLANE, 8'd2);
        add_req(CMD_READ,  15'h0000, 8'h00, 1, 8'hFF);
        add_reg(CFG_WRITE_MODE, {6'd0, WMODE_LATCH});
        add_req(CMD_WRITE, 15'h1234, 8'h00, 0, 8'h00);
        add_req(CMD_READ,  15'h1234, 8'h00, 1, 8'hFF);
        add_reg(CFG_WRITE_MODE, {6'd0, WMODE_MASK});
        add_reg(CFG_PLANE_MAP_MASK, 8'h05);
        add_req(CMD_WRITE, 15'h7FFF, 8'hA5, 0, 8'h00);
        add_reg(CFG_READ_PLANE, 8'd0);
        add_req(CMD_READ,  15'h7FFF, 8'h00, 1, 8'hA5);
        add_reg(CFG_READ_PLANE, 8'd1);
        add_req(CMD_READ,  15'h7FFF, 8'h00, 1, 8'hFF);
        add_reg(CFG_PLANE_MAP_MASK, 8'h00);              // empty map: no change
        add_req(CMD_WRITE, 15'h7FFF, 8'hFF, 0, 8'h00);
        add_req(CMD_READ,  15'h7FFF, 8'h00, 1, 8'hFF);
        add_reg(CFG_PLANE_MAP_MASK, 8'h0F);
        add_req(CMD_WRITE, 15'h0000, 8'hF0, 0, 8'h00);   // set pixels become 15 -> 4
        add_reg(CFG_READ_PLANE, 8'd3);
        add_req(CMD_READ,  15'h0000, 8'h00, 1, 8'h00);
        add_reg(CFG_READ_PLANE, 8'd2);
        add_req(CMD_READ,  15'h0000, 8'h00, 1, 8'hF0);
        add_reg(CFG_WRITE_MODE, {6'd0, WMODE_UNUSED});   // writes ignored
        add_req(CMD_WRITE, 15'h0000, 8'h00, 0, 8'h00);
        add_req(CMD_READ,  15'h0000, 8'h00, 1, 8'hF0);
        add_reg(CFG_WRITE_MODE, {6'd0, WMODE_COLOR});
        add_reg(CFG_PIXEL_WRITE_MASK, 8'h00);
        add_req(CMD_WRITE, 15'h0000, 8'h01, 0, 8'h00);
        add_reg(CFG_PIXEL_WRITE_MASK, 8'h81);
        add_req(CMD_WRITE, 15'h0000, 8'hFE, 0, 8'h00);
        add_req(CMD_READ,  15'h0000, 8'h00, 1, 8'hF1);
        add_reg(CFG_READ_PLANE, 8'd3);
        add_req(CMD_READ,  15'h0000, 8'h00, 1, 8'h81);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_script[k])
        begin
            if (directed_script[k].is_cfg)
            begin
                settle_block();
                write_register(directed_script[k].reg_idx, directed_script[k].reg_val);
            end
            else
                send_request(directed_script[k].cmd, directed_script[k].off,
                             directed_script[k].wdata, directed_script[k].has_known,
                             directed_script[k].known);
        end

        // fill a working set of words so reads and partial writes stay defined
        settle_block();
        write_register(CFG_WRITE_MODE, {6'd0, WMODE_COLOR});
        write_register(CFG_PIXEL_WRITE_MASK, 8'hFF);
        addr_pool[0] = 15'h0000;
        addr_pool[1] = 15'h7FFF;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = 15'($urandom_range(0, 32767));
        foreach (addr_pool[i])
            send_request(CMD_WRITE, addr_pool[i], 8'($urandom_range(0, 255)), 0, 8'h00);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int seg = 0; seg < 2; seg++)
            begin
                settle_block();
                pick_settings();
                repeat (SEGMENT_ITEMS) random_access();
            end
        end

        settle_block();
        repeat (20) @(negedge clk);
        if (pending_reads.size() != 0)
            note_error($sformatf("%0d read results never arrived", pending_reads.size()));

        $display("ran %0d requests, %0d read results checked", requests_sent, reads_checked);
        $display("writes by mode mask/latch/color/unused: %0d/%0d/%0d/%0d, %0d errors",
                 writes_per_mode[0], writes_per_mode[1], writes_per_mode[2],
                 writes_per_mode[3], errors);
        if (errors == 0)
            $display("planar_video_memory_access_core verification clean");
        else
            $display("planar_video_memory_access_core verification failed");
        $finish;
    end

endmodule
